// ----- rtl/rmsq_pkg.sv -----
package rmsq_pkg;

   localparam int unsigned MAX_LEN_DEF = 1024;
   localparam int unsigned NUM_CLASSES = 4;
   localparam int unsigned IDX_W       = 10;

   localparam logic [1:0] ACTION_CLEAR  = 2'd0;
   localparam logic [1:0] ACTION_APPEND = 2'd1;
   localparam logic [1:0] ACTION_QUERY  = 2'd2;

   localparam logic [7:0] SYM_A = 8'h41;
   localparam logic [7:0] SYM_C = 8'h43;
   localparam logic [7:0] SYM_G = 8'h47;

   typedef struct packed {
      logic [1:0]       action;
      logic [7:0]       symbol;
      logic [IDX_W-1:0] start_index;
      logic [IDX_W-1:0] end_index;
   } req_type;

   typedef struct packed {
      logic [2:0] min_class;
      logic       bad_range;
   } rsp_type;

   // Slot 0 holds class 1 ('A') up to slot 3 for every other byte.
   function automatic logic [1:0] symbol_slot(input logic [7:0] sym);
      logic [1:0] slot;
      case (sym)
         SYM_A:   slot = 2'd0;
         SYM_C:   slot = 2'd1;
         SYM_G:   slot = 2'd2;
         default: slot = 2'd3;
      endcase
      return slot;
   endfunction

endpackage

// ----- rtl/rmsq_count_ram.sv -----
module rmsq_count_ram
   import rmsq_pkg::*;
#(
   parameter int unsigned Depth = MAX_LEN_DEF + 1,
   parameter int unsigned AddrW = $clog2(MAX_LEN_DEF + 1),
   parameter int unsigned DataW = NUM_CLASSES * $clog2(MAX_LEN_DEF + 1)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [DataW-1:0] rd_data_a,
   output logic [DataW-1:0] rd_data_b
);

   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_data_a_ff;
   logic [DataW-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/range_min_symbol_query_core.sv -----
// Range minimum symbol query core.
// Requests arrive on the req_ channel (req_valid, req_stall, req_data) and carry
// an action: clear, append a symbol byte, or query an inclusive index range.
// Only a query produces a response on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data) with the smallest symbol class in the range, or bad_range set and
// class 0 when the range is empty or reaches past the stored sequence.
// The core accepts one request per cycle while req_stall is low. A query
// response is registered: the two prefix-count entries are read into the RAM
// output registers at the accepting edge, and the class compare then loads the
// output register when the read stage can move to it. Appends write one entry
// and finish in the cycle they are taken; the counts of the last entry are
// kept in a register, so no read is needed.
// When the receiver stalls, the response holds in the output register and
// one more query may wait behind it; after that req_stall rises until the
// response is taken. Appends beyond the maximum length are dropped.
// Reset clears the length and the pipeline valids; entry zero of the count
// memory is never written and the read logic takes it as all zero, so no
// clearing pass is needed and the core is ready as soon as reset is released.
module range_min_symbol_query_core
   import rmsq_pkg::*;
#(
   parameter int unsigned MaxLen = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned LenW = $clog2(MaxLen + 1);
   localparam int unsigned CntW = LenW;
   localparam int unsigned EntW = NUM_CLASSES * CntW;
   localparam int unsigned CmpW = (LenW > IDX_W) ? LenW : IDX_W;

   typedef logic [NUM_CLASSES-1:0][CntW-1:0] counts_type;

   logic [LenW-1:0] len_ff, len_in;
   counts_type      tail_ff, tail_in;

   logic            s1_valid_ff, s1_bad_ff, s1_lo_zero_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic            req_fire;
   logic            is_query;
   logic            s1_move;
   logic [CmpW-1:0] lo_ext, hi_ext, len_ext;
   logic            range_bad;

   logic            wr_en;
   logic [LenW-1:0] wr_addr;
   logic [LenW-1:0] rd_addr_a, rd_addr_b;
   logic [EntW-1:0] rd_data_a, rd_data_b;
   counts_type      lo_cnt, hi_cnt;
   logic [2:0]      found;

   // A query leaves the read stage unless a stalled response holds the output register; requests stall meanwhile.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign is_query  = req_data.action == ACTION_QUERY;

   assign lo_ext    = CmpW'(req_data.start_index);
   assign hi_ext    = CmpW'(req_data.end_index);
   assign len_ext   = CmpW'(len_ff);
   assign range_bad = (lo_ext > hi_ext) || (hi_ext >= len_ext);

   assign rd_addr_a = LenW'(lo_ext);
   assign rd_addr_b = LenW'(hi_ext + CmpW'(1));

   always_comb begin
      len_in  = len_ff;
      tail_in = tail_ff;
      wr_en   = 1'b0;
      wr_addr = len_ff + LenW'(1);
      if (req_fire) begin
         case (req_data.action)
            ACTION_CLEAR: begin
               len_in  = '0;
               tail_in = '0;
            end
            ACTION_APPEND: begin
               if (len_ff < LenW'(MaxLen)) begin
                  tail_in[symbol_slot(req_data.symbol)] =
                     tail_ff[symbol_slot(req_data.symbol)] + CntW'(1);
                  wr_en  = 1'b1;
                  len_in = len_ff + LenW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         tail_ff <= '0;
      end else begin
         len_ff  <= len_in;
         tail_ff <= tail_in;
      end
   end

   rmsq_count_ram #(
      .Depth (MaxLen + 1),
      .AddrW (LenW),
      .DataW (EntW)
   ) u_count_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (EntW'(tail_in)),
      .rd_en     (req_fire && is_query),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire && is_query) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_query) begin
         s1_bad_ff     <= range_bad;
         s1_lo_zero_ff <= req_data.start_index == '0;
      end
   end

   // Entry zero is never written; it stands for the all-zero counts.
   assign lo_cnt = s1_lo_zero_ff ? counts_type'('0) : counts_type'(rd_data_a);
   assign hi_cnt = counts_type'(rd_data_b);

   always_comb begin
      found = 3'd0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (hi_cnt[c] > lo_cnt[c]) begin
            found = 3'(c + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.min_class <= s1_bad_ff ? 3'd0 : found;
         rsp_data_ff.bad_range <= s1_bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/rmsq_checker.sv -----
module rmsq_checker
   import rmsq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A response waiting on the receiver holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_range |-> rsp_data.min_class == 3'd0)
      else $error("bad range response carries a class");

   // A good range holds at least one symbol, so some class must be found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_range |->
         rsp_data.min_class != 3'd0 && rsp_data.min_class <= 3'd4)
      else $error("good range response without a valid class");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A request held back by the core keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

endmodule

bind range_min_symbol_query_core rmsq_checker u_checker (.*);
